[design/idc_pkg.sv]
package idc_pkg;

    localparam int unsigned MONTH_W = 4;
    localparam int unsigned DAY_W   = 5;
    localparam int unsigned YEAR_W  = 14;
    localparam int unsigned COUNT_W = 22;
    localparam int unsigned DNUM_W  = 23;
    localparam int unsigned Q100_W  = 8;
    localparam int unsigned LEAPS_W = 13;
    localparam int unsigned PART_W  = 9;

    localparam logic [12:0]        RECIP100    = 13'd5243;
    localparam int unsigned        RECIP_SHIFT = 19;
    localparam logic [6:0]         HUNDRED     = 7'd100;
    localparam logic [8:0]         DAYS_YEAR   = 9'd365;
    localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

    localparam logic [MONTH_W-1:0] JAN = 4'd1;
    localparam logic [MONTH_W-1:0] FEB = 4'd2;
    localparam logic [MONTH_W-1:0] DEC = 4'd12;

    typedef struct packed {
        logic [MONTH_W-1:0] start_month;
        logic [DAY_W-1:0]   start_day;
        logic [YEAR_W-1:0]  start_year;
        logic [MONTH_W-1:0] end_month;
        logic [DAY_W-1:0]   end_day;
        logic [YEAR_W-1:0]  end_year;
    } req_t;

    typedef struct packed {
        logic [COUNT_W-1:0] day_count;
        logic               valid_res;
    } rsp_t;

    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } pipe_en_t;

    function automatic logic [PART_W-1:0] days_before(input logic [MONTH_W-1:0] m);
        logic [PART_W-1:0] r;
        unique case (m)
            4'd1:    r = 9'd0;
            4'd2:    r = 9'd31;
            4'd3:    r = 9'd59;
            4'd4:    r = 9'd90;
            4'd5:    r = 9'd120;
            4'd6:    r = 9'd151;
            4'd7:    r = 9'd181;
            4'd8:    r = 9'd212;
            4'd9:    r = 9'd243;
            4'd10:   r = 9'd273;
            4'd11:   r = 9'd304;
            4'd12:   r = 9'd334;
            default: r = 9'd0;
        endcase
        return r;
    endfunction

    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
        logic [DAY_W-1:0] r;
        unique case (m) inside
            4'd2:                    r = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11: r = 5'd30;
            default:                 r = 5'd31;
        endcase
        return r;
    endfunction

endpackage

[design/idc_pipe_ctrl.sv]
module idc_pipe_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output idc_pkg::pipe_en_t en
);
    import idc_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic v1_next, v2_next, v3_next, v4_next;
    logic adv1, adv2, adv3, adv4;

    always_comb
    begin
        adv4 = !v4_reg || rsp_ready;
        adv3 = !v3_reg || adv4;
        adv2 = !v2_reg || adv3;
        adv1 = !v1_reg || adv2;
        v1_next = adv1 ? req_valid : v1_reg;
        v2_next = adv2 ? v1_reg    : v2_reg;
        v3_next = adv3 ? v2_reg    : v3_reg;
        v4_next = adv4 ? v3_reg    : v4_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
            v4_reg <= v4_next;
        end
    end

    assign req_ready = adv1;
    assign rsp_valid = v4_reg;
    assign en.s1     = adv1;
    assign en.s2     = adv2;
    assign en.s3     = adv3;
    assign en.s4     = adv4;

endmodule

[design/idc_day_num.sv]
module idc_day_num #(
    parameter int unsigned YEAR_MAX = 9999
) (
    input  logic                          clk,
    input  idc_pkg::pipe_en_t             en,
    input  logic [idc_pkg::MONTH_W-1:0]   month,
    input  logic [idc_pkg::DAY_W-1:0]     day,
    input  logic [idc_pkg::YEAR_W-1:0]    year,
    output logic [idc_pkg::DNUM_W-1:0]    num,
    output logic                          ok
);
    import idc_pkg::*;

    localparam logic [16:0] YMAX = 17'(YEAR_MAX);
    localparam int unsigned PROD_W = YEAR_W + 13;

    // stage 1: year / 100 by reciprocal
    logic [PROD_W-1:0]  prod;
    logic [MONTH_W-1:0] m1_reg;
    logic [DAY_W-1:0]   d1_reg;
    logic [YEAR_W-1:0]  y1_reg;
    logic [Q100_W-1:0]  q100_reg, q100_next;

    assign prod      = PROD_W'(year) * PROD_W'(RECIP100);
    assign q100_next = Q100_W'(prod >> RECIP_SHIFT);

    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            m1_reg   <= month;
            d1_reg   <= day;
            y1_reg   <= year;
            q100_reg <= q100_next;
        end
    end

    // stage 2: leap, checks, partial sums
    logic [YEAR_W-1:0]  rem;
    logic               rem_nz, div400, leap, ok2_next;
    logic [LEAPS_W-1:0] leaps_reg, leaps_next;
    logic [DNUM_W-1:0]  y365_reg, y365_next;
    logic [PART_W-1:0]  part_reg, part_next;
    logic               ok2_reg;

    always_comb
    begin
        rem    = y1_reg - YEAR_W'(YEAR_W'(q100_reg) * YEAR_W'(HUNDRED));
        rem_nz = (rem != '0);
        div400 = !rem_nz && (q100_reg[1:0] == 2'b00);
        leap   = div400 || ((y1_reg[1:0] == 2'b00) && rem_nz);
        ok2_next = (m1_reg >= JAN) && (m1_reg <= DEC) && (d1_reg != '0)
                   && ({3'b000, y1_reg} <= YMAX)
                   && (d1_reg <= month_len(m1_reg, leap));
        leaps_next = LEAPS_W'(y1_reg[YEAR_W-1:2])
                     + LEAPS_W'(y1_reg[1:0] != 2'b00)
                     - LEAPS_W'(q100_reg)
                     - LEAPS_W'(rem_nz)
                     + LEAPS_W'(q100_reg[Q100_W-1:2])
                     + LEAPS_W'(!div400);
        y365_next = DNUM_W'(y1_reg) * DNUM_W'(DAYS_YEAR);
        part_next = days_before(m1_reg) + PART_W'(d1_reg) - PART_W'(1)
                    + PART_W'((m1_reg > FEB) && leap);
    end

    always_ff @(posedge clk)
    begin
        if (en.s2)
        begin
            leaps_reg <= leaps_next;
            y365_reg  <= y365_next;
            part_reg  <= part_next;
            ok2_reg   <= ok2_next;
        end
    end

    // stage 3: day number
    logic [DNUM_W-1:0] num_reg, num_next;
    logic              ok3_reg;

    assign num_next = y365_reg + DNUM_W'(leaps_reg) + DNUM_W'(part_reg);

    always_ff @(posedge clk)
    begin
        if (en.s3)
        begin
            num_reg <= num_next;
            ok3_reg <= ok2_reg;
        end
    end

    assign num = num_reg;
    assign ok  = ok3_reg;

endmodule

[design/inclusive_day_count_between_dates.sv]
// Inclusive day count between two Gregorian dates.
//
// Input channel req_valid/req_ready/req carries one word per item: start and
// end dates as month, day and year. Output channel rsp_valid/rsp_ready/rsp
// carries one word per item: the count of days from start to end, both
// counted, and valid_res. A malformed date (bad month, day out of range for
// that month and year, year above YEAR_MAX) or an end before the start
// gives valid_res = 0 with a zero count. Counts beyond the field saturate.
//
// Four register stages: year / 100 by reciprocal multiply, leap and range
// checks with partial sums, day number, then difference and the output
// register. A word accepted on req moves through the stage registers in that
// order and is shown on rsp from the output register until it is taken.
// One word per cycle is taken and delivered while rsp_ready stays high.
// When rsp_ready is low the pipeline closes up its bubbles and then holds;
// req_ready drops only when every stage is full, and nothing is lost.
// Reset clears all stage valid flags; the block is empty and ready at once.
module inclusive_day_count_between_dates #(
    parameter int unsigned YEAR_MAX = 9999
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  idc_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output idc_pkg::rsp_t rsp
);
    import idc_pkg::*;

    pipe_en_t          en;
    logic [DNUM_W-1:0] num_s, num_e;
    logic              ok_s, ok_e;

    idc_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .en        (en)
    );

    idc_day_num #(.YEAR_MAX(YEAR_MAX)) u_start (
        .clk   (clk),
        .en    (en),
        .month (req.start_month),
        .day   (req.start_day),
        .year  (req.start_year),
        .num   (num_s),
        .ok    (ok_s)
    );

    idc_day_num #(.YEAR_MAX(YEAR_MAX)) u_end (
        .clk   (clk),
        .en    (en),
        .month (req.end_month),
        .day   (req.end_day),
        .year  (req.end_year),
        .num   (num_e),
        .ok    (ok_e)
    );

    logic [DNUM_W:0]   diff;
    logic [DNUM_W-1:0] count;
    rsp_t              rsp_reg, rsp_next;

    always_comb
    begin
        diff  = {1'b0, num_e} - {1'b0, num_s};
        count = diff[DNUM_W-1:0] + DNUM_W'(1);
        rsp_next = '0;
        if (ok_s && ok_e && !diff[DNUM_W])
        begin
            rsp_next.valid_res = 1'b1;
            rsp_next.day_count = (count > DNUM_W'(COUNT_MAX)) ? COUNT_MAX
                                                              : count[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.s4)
            rsp_reg <= rsp_next;
    end

    assign rsp = rsp_reg;

endmodule

[design/idc_checker.sv]
module idc_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          req_valid,
    input logic          req_ready,
    input idc_pkg::req_t req,
    input logic          rsp_valid,
    input logic          rsp_ready,
    input idc_pkg::rsp_t rsp
);
    import idc_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("rsp word changed while stalled");

    a_zero_when_bad: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.valid_res |-> rsp.day_count == '0)
        else $error("nonzero count on invalid result");

    a_nonzero_when_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.valid_res |-> rsp.day_count != '0)
        else $error("zero count on valid result");

    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !rsp_valid |-> req_ready)
        else $error("input stalled with empty output");

endmodule

bind inclusive_day_count_between_dates idc_checker u_idc_checker (.*);
